// ===== design/tacr_pkg.sv =====
// Shared constants, register indexes and control types for the touch calibrate unit.
package tacr_pkg;

    localparam int PANEL_WIDTH  = 320;
    localparam int PANEL_HEIGHT = 240;

    localparam int RAW_W   = 10;
    localparam int PRESS_W = 8;
    localparam int SCR_W   = 9;
    localparam int NAT_W   = 10;
    localparam int WORD_W  = 32;
    localparam int IDX_W   = 8;
    localparam int CNT_W   = 5;
    localparam int ROT_W   = 2;
    localparam int TDATA_W = 32;

    localparam logic [NAT_W-1:0]  NAT_PW  = NAT_W'(PANEL_WIDTH);
    localparam logic [NAT_W-1:0]  NAT_PH  = NAT_W'(PANEL_HEIGHT);
    localparam logic [WORD_W-1:0] SIZE_X  = WORD_W'(PANEL_WIDTH);
    localparam logic [WORD_W-1:0] SIZE_Y  = WORD_W'(PANEL_HEIGHT);
    localparam logic [WORD_W-1:0] LIMIT_X = WORD_W'(2 * PANEL_WIDTH);
    localparam logic [WORD_W-1:0] LIMIT_Y = WORD_W'(2 * PANEL_HEIGHT);

    localparam logic [IDX_W-1:0] REG_COEF_A  = 8'd0;
    localparam logic [IDX_W-1:0] REG_COEF_B  = 8'd1;
    localparam logic [IDX_W-1:0] REG_COEF_C  = 8'd2;
    localparam logic [IDX_W-1:0] REG_COEF_D  = 8'd3;
    localparam logic [IDX_W-1:0] REG_COEF_E  = 8'd4;
    localparam logic [IDX_W-1:0] REG_COEF_F  = 8'd5;
    localparam logic [IDX_W-1:0] REG_DIVISOR = 8'd6;
    localparam logic [IDX_W-1:0] REG_ORIENT  = 8'd7;

    localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
    localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
    localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
    localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic capture;     // input word accepted
        logic mul_first;   // prod = kx * raw_x
        logic mul_second;  // prod = ky * raw_y, sum = k0 + prod
        logic sum_load;    // dividend = sum + prod, clear remainder
        logic div_step;    // one restoring divide step
        logic commit;      // clamp quotient into native coordinate
        logic axis_y;      // 0: x axis, 1: y axis
        logic load_out;    // rotate and load output register
    } tacr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic axis_stale;  // held raw differs from used raw on current axis
        logic out_busy;    // output register full and not being taken
    } tacr_stat_t;

endpackage

// ===== design/tacr_ctrl.sv =====
// Sequencing state machine for the touch calibrate unit.
module tacr_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  tacr_pkg::tacr_stat_t   stat,
    output tacr_pkg::tacr_cmd_t    cmd
);
    import tacr_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_MUL0   = 3'd2;
    localparam logic [2:0] S_MUL1   = 3'd3;
    localparam logic [2:0] S_SUM    = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_CLAMP  = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WORD_W - 1);

    logic [2:0]       state_reg, state_next;
    logic             axis_reg, axis_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cnt_next   = cnt_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.axis_y = axis_reg;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    axis_next   = 1'b0;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.axis_stale)
                    state_next = S_MUL0;
                else if (axis_reg)
                    state_next = S_FINISH;
                else
                    axis_next = 1'b1;
            end
            S_MUL0:
            begin
                cmd.mul_first = 1'b1;
                state_next    = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul_second = 1'b1;
                state_next     = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_load = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                    state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                cmd.commit = 1'b1;
                if (axis_reg)
                    state_next = S_FINISH;
                else
                begin
                    axis_next  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/tacr_dp.sv =====
// Datapath: config registers, held/used raw state, affine MAC, serial divider, rotation.
module tacr_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tacr_pkg::TDATA_W-1:0]  s_tdata,
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tacr_pkg::TDATA_W-1:0]  m_tdata,
    output logic                          m_tuser,
    input  logic                          cfg_we,
    input  logic [tacr_pkg::IDX_W-1:0]    cfg_index,
    input  logic [tacr_pkg::WORD_W-1:0]   cfg_data,
    input  tacr_pkg::tacr_cmd_t           cmd,
    output tacr_pkg::tacr_stat_t          stat
);
    import tacr_pkg::*;

    logic [WORD_W-1:0]  coef_a_reg, coef_b_reg, coef_c_reg;
    logic [WORD_W-1:0]  coef_d_reg, coef_e_reg, coef_f_reg;
    logic [WORD_W-1:0]  divisor_reg;
    logic [ROT_W-1:0]   orient_reg;

    logic [RAW_W-1:0]   held_x_reg, held_y_reg, used_x_reg, used_y_reg;
    logic [NAT_W-1:0]   native_x_reg, native_y_reg;
    logic               touched_reg;
    logic [PRESS_W-1:0] press_reg;

    logic [WORD_W-1:0]  prod_reg, sum_reg, quo_reg, rem_reg;

    logic               out_valid_reg;
    logic               out_touched_reg;
    logic [PRESS_W-1:0] out_press_reg;
    logic [SCR_W-1:0]   out_x_reg, out_y_reg;

    // configuration; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg  <= '0;
            coef_b_reg  <= '0;
            coef_c_reg  <= '0;
            coef_d_reg  <= '0;
            coef_e_reg  <= '0;
            coef_f_reg  <= '0;
            divisor_reg <= '0;
            orient_reg  <= ROT_0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COEF_A:  coef_a_reg  <= cfg_data;
                REG_COEF_B:  coef_b_reg  <= cfg_data;
                REG_COEF_C:  coef_c_reg  <= cfg_data;
                REG_COEF_D:  coef_d_reg  <= cfg_data;
                REG_COEF_E:  coef_e_reg  <= cfg_data;
                REG_COEF_F:  coef_f_reg  <= cfg_data;
                REG_DIVISOR: divisor_reg <= cfg_data;
                REG_ORIENT:  orient_reg  <= cfg_data[ROT_W-1:0];
                default:     ;
            endcase
        end
    end

    // per-axis operand selection
    logic [WORD_W-1:0] kx, ky, k0, size_w, limit_w;
    always_comb
    begin
        if (cmd.axis_y)
        begin
            kx      = coef_d_reg;
            ky      = coef_e_reg;
            k0      = coef_f_reg;
            size_w  = SIZE_Y;
            limit_w = LIMIT_Y;
        end
        else
        begin
            kx      = coef_a_reg;
            ky      = coef_b_reg;
            k0      = coef_c_reg;
            size_w  = SIZE_X;
            limit_w = LIMIT_X;
        end
    end

    assign stat.axis_stale = cmd.axis_y ? (held_y_reg != used_y_reg)
                                        : (held_x_reg != used_x_reg);
    assign stat.out_busy   = out_valid_reg && !m_tready;

    // shared 32x10 multiplier, product wraps to 32 bits
    logic [WORD_W-1:0] mul_a, mul_b, prod_next;
    assign mul_a     = cmd.mul_first ? kx : ky;
    assign mul_b     = cmd.mul_first ? WORD_W'(held_x_reg) : WORD_W'(held_y_reg);
    assign prod_next = mul_a * mul_b;

    // restoring divide step; a zero divisor yields all-ones quotient
    logic [WORD_W:0] rem_shift, rem_diff;
    logic            quo_bit;
    assign rem_shift = {rem_reg, quo_reg[WORD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};
    assign quo_bit   = (rem_shift >= {1'b0, divisor_reg});

    // clamp against native size
    logic [NAT_W-1:0] clamped;
    always_comb
    begin
        if (quo_reg >= limit_w)
            clamped = '0;
        else if (quo_reg >= size_w)
            clamped = NAT_W'(size_w - 1'b1);
        else
            clamped = quo_reg[NAT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_x_reg   <= '0;
            held_y_reg   <= '0;
            used_x_reg   <= '0;
            used_y_reg   <= '0;
            native_x_reg <= '0;
            native_y_reg <= '0;
        end
        else
        begin
            if (cmd.capture && s_tuser)
            begin
                held_x_reg <= s_tdata[RAW_W-1:0];
                held_y_reg <= s_tdata[2*RAW_W-1:RAW_W];
            end
            if (cmd.commit)
            begin
                if (cmd.axis_y)
                begin
                    used_y_reg   <= held_y_reg;
                    native_y_reg <= clamped;
                end
                else
                begin
                    used_x_reg   <= held_x_reg;
                    native_x_reg <= clamped;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            touched_reg <= s_tuser;
            press_reg   <= s_tdata[2*RAW_W+PRESS_W-1:2*RAW_W];
        end
        if (cmd.mul_first || cmd.mul_second)
            prod_reg <= prod_next;
        if (cmd.mul_second)
            sum_reg <= k0 + prod_reg;
        if (cmd.sum_load)
        begin
            quo_reg <= sum_reg + prod_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[WORD_W-2:0], quo_bit};
            rem_reg <= quo_bit ? rem_diff[WORD_W-1:0] : rem_shift[WORD_W-1:0];
        end
    end

    // rotation
    logic [NAT_W-1:0] rot_x, rot_y;
    always_comb
    begin
        case (orient_reg)
            ROT_0:
            begin
                rot_x = native_x_reg;
                rot_y = native_y_reg;
            end
            ROT_90:
            begin
                rot_x = native_y_reg;
                rot_y = NAT_PW - native_x_reg;
            end
            ROT_180:
            begin
                rot_x = NAT_PW - native_x_reg;
                rot_y = NAT_PH - native_y_reg;
            end
            default:
            begin
                rot_x = NAT_PH - native_y_reg;
                rot_y = native_x_reg;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_touched_reg <= touched_reg;
            out_press_reg   <= touched_reg ? press_reg : '0;
            out_x_reg       <= touched_reg ? rot_x[SCR_W-1:0] : '0;
            out_y_reg       <= touched_reg ? rot_y[SCR_W-1:0] : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_touched_reg;
    assign m_tdata  = {{(TDATA_W - PRESS_W - 2*SCR_W){1'b0}},
                       out_y_reg, out_x_reg, out_press_reg};

endmodule

// ===== design/touch_affine_calibrate_rotate_unit.sv =====
// Top level: touch sample affine calibration, clamp and display rotation.
// Per word: each raw axis is checked; an axis whose held raw value is unchanged is skipped,
// a stale one runs 3 multiply/add steps, 32 divide steps and a clamp, then the result
// is rotated and loaded out. One word is in flight at a time; the serial divider sets the rate.
// The next input word is taken while a finished result waits in the output register.
// Reset (rst_n, async, active low) clears config, held/used raw and native coordinates.
module touch_affine_calibrate_rotate_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tacr_pkg::TDATA_W-1:0]  s_tdata,   // raw_x[9:0], raw_y[19:10], pressure[27:20]
    input  logic                          s_tuser,   // consistent
    // output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tacr_pkg::TDATA_W-1:0]  m_tdata,   // report_pressure[7:0], screen_x[16:8],
                                                     // screen_y[25:17]
    output logic                          m_tuser,   // touched
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tacr_pkg::IDX_W-1:0]    cfg_index,
    input  logic [tacr_pkg::WORD_W-1:0]   cfg_data
);
    import tacr_pkg::*;

    tacr_cmd_t  cmd;
    tacr_stat_t stat;

    // config writes are never stalled; indexes past the list are dropped
    assign cfg_ready = 1'b1;

    // controller: accept, per-axis recompute sequencing, divide count, output hand-off
    tacr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: MAC over wrapping 32-bit words, restoring divider, clamp, rotate
    tacr_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== bench/touch_affine_calibrate_rotate_unit_tb.sv =====
// Self-checking bench for the touch calibrate/rotate unit: directed table, then random phases.
module touch_affine_calibrate_rotate_unit_tb;

    import tacr_pkg::*;

    // Run sizing. 800 random words plus the directed table, sender gaps and sink stalls
    // stay far below the cycle limit.
    localparam int NUM_PHASES      = 10;
    localparam int WORDS_PER_PHASE = 80;
    localparam int DRAIN_CYCLES    = 100;
    localparam int CYCLE_LIMIT     = 1_000_000;

    // Register indexes past the end of the map; writes there must be dropped.
    localparam logic [IDX_W-1:0] REG_PAST_END  = REG_ORIENT + 8'd1;
    localparam logic [IDX_W-1:0] REG_INDEX_MAX = '1;

    // One output word, unpacked from m_tdata/m_tuser.
    typedef struct packed {
        logic               touched;
        logic [PRESS_W-1:0] pressure;
        logic [SCR_W-1:0]   x;
        logic [SCR_W-1:0]   y;
    } touch_report_t;

    typedef enum logic { STEP_REG, STEP_SAMPLE } plan_kind_t;

    // One row of the directed table: either a register write or a sample word.
    // Rows marked fixed carry their expected report; others use the predictor.
    typedef struct {
        plan_kind_t         kind;
        logic [IDX_W-1:0]   index;
        logic [WORD_W-1:0]  value;
        logic [RAW_W-1:0]   rx;
        logic [RAW_W-1:0]   ry;
        logic [PRESS_W-1:0] pr;
        logic               cons;
        bit                 fixed;
        touch_report_t      want;
    } plan_row_t;

    typedef enum logic [1:0] { CAL_SANE, CAL_RAW, CAL_EXTREME } cal_style_t;
    typedef enum logic [1:0] { SINK_OPEN, SINK_CHOPPY, SINK_STARVED } sink_pace_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata   = '0;   // raw_x[9:0], raw_y[19:10], pressure[27:20]
    logic                 s_tuser   = 1'b0; // consistent
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;          // report_pressure[7:0], screen_x[16:8],
                                            // screen_y[25:17]
    logic                 m_tuser;          // touched
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [IDX_W-1:0]     cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data  = '0;

    // Predictor copy of the configuration.
    logic [WORD_W-1:0]    cal_coef [6];
    logic [WORD_W-1:0]    cal_divisor;
    logic [ROT_W-1:0]     cal_orient;

    // Predictor copy of the block state.
    logic [RAW_W-1:0]     held_x, held_y;
    logic [RAW_W-1:0]     used_x, used_y;
    logic [NAT_W-1:0]     nat_x, nat_y;

    touch_report_t        pending_reports [$];
    plan_row_t            directed_plan [$];

    int                   burst_left      = 0;
    int                   samples_sent    = 0;
    int                   regs_written    = 0;
    int                   reports_checked = 0;
    int                   touched_reports = 0;
    int                   mismatch_count  = 0;
    int                   cycle_count     = 0;

    sink_pace_t           sink_pace = SINK_OPEN;
    int                   sink_left = 0;

    touch_affine_calibrate_rotate_unit i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Affine sum over wrapping 32-bit math, unsigned divide, then clamp.
    // Zero divisor reads as an all-ones quotient, which lands in the zero band.
    function automatic logic [NAT_W-1:0] clamp_axis(input logic [WORD_W-1:0] kx,
                                                    input logic [WORD_W-1:0] ky,
                                                    input logic [WORD_W-1:0] k0,
                                                    input logic [WORD_W-1:0] size);
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] quot;
        sum  = kx * WORD_W'(held_x) + ky * WORD_W'(held_y) + k0;
        quot = (cal_divisor == '0) ? '1 : sum / cal_divisor;
        if (quot >= (size << 1))
            return '0;
        if (quot >= size)
            return NAT_W'(size - 1);
        return NAT_W'(quot);
    endfunction

    // Advance the state by one sample and return the report it should produce.
    function automatic touch_report_t predict_report(input logic [RAW_W-1:0] rx,
                                                     input logic [RAW_W-1:0] ry,
                                                     input logic [PRESS_W-1:0] pr,
                                                     input logic cons);
        touch_report_t    rep;
        logic [NAT_W-1:0] ox;
        logic [NAT_W-1:0] oy;
        if (cons)
        begin
            held_x = rx;
            held_y = ry;
        end
        // an axis is only recomputed when its held raw value moved
        if (held_x != used_x)
        begin
            used_x = held_x;
            nat_x  = clamp_axis(cal_coef[REG_COEF_A], cal_coef[REG_COEF_B],
                                cal_coef[REG_COEF_C], SIZE_X);
        end
        if (held_y != used_y)
        begin
            used_y = held_y;
            nat_y  = clamp_axis(cal_coef[REG_COEF_D], cal_coef[REG_COEF_E],
                                cal_coef[REG_COEF_F], SIZE_Y);
        end
        case (cal_orient)
            ROT_0:
            begin
                ox = nat_x;
                oy = nat_y;
            end
            ROT_90:
            begin
                ox = nat_y;
                oy = NAT_PW - nat_x;
            end
            ROT_180:
            begin
                ox = NAT_PW - nat_x;
                oy = NAT_PH - nat_y;
            end
            default:
            begin
                ox = NAT_PH - nat_y;
                oy = nat_x;
            end
        endcase
        rep.touched  = cons;
        rep.pressure = cons ? pr : '0;
        rep.x        = cons ? ox[SCR_W-1:0] : '0;
        rep.y        = cons ? oy[SCR_W-1:0] : '0;
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------

    function automatic void plan_reg(input logic [IDX_W-1:0] idx,
                                     input logic [WORD_W-1:0] value);
        plan_row_t row;
        row       = '{kind: STEP_REG, default: '0};
        row.index = idx;
        row.value = value;
        directed_plan.push_back(row);
    endfunction

    function automatic void plan_sample(input int rx, input int ry, input int pr,
                                        input bit cons, input bit fixed,
                                        input int w_touch, input int w_press,
                                        input int w_x, input int w_y);
        plan_row_t row;
        row               = '{kind: STEP_SAMPLE, default: '0};
        row.rx            = RAW_W'(rx);
        row.ry            = RAW_W'(ry);
        row.pr            = PRESS_W'(pr);
        row.cons          = cons;
        row.fixed         = fixed;
        row.want.touched  = w_touch[0];
        row.want.pressure = PRESS_W'(w_press);
        row.want.x        = SCR_W'(w_x);
        row.want.y        = SCR_W'(w_y);
        directed_plan.push_back(row);
    endfunction

    // Raw value for the random part: often a repeat, so the no-recompute path gets traffic.
    function automatic logic [RAW_W-1:0] next_raw(input logic [RAW_W-1:0] prev);
        case ($urandom_range(0, 7))
            0, 1:    return prev;
            2:       return ($urandom_range(0, 1) != 0) ? '1 : '0;
            default: return RAW_W'($urandom_range(0, 1023));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Stop sending and wait until every expected report has come back. Every word
    // yields a report, so the block is idle once the queue is empty.
    task automatic drain_reports();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    // Leaves cfg_valid high so back-to-back writes need no extra edge; the next
    // sample word lowers it.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_COEF_A, REG_COEF_B, REG_COEF_C,
            REG_COEF_D, REG_COEF_E, REG_COEF_F: cal_coef[idx] = value;
            REG_DIVISOR:                        cal_divisor   = value;
            REG_ORIENT:                         cal_orient    = value[ROT_W-1:0];
            default:                            ;
        endcase
        regs_written++;
    endtask

    // Send one sample word. Bursts of random length with random gaps in between;
    // valid stays high across a burst so each word is offered as soon as the last is taken.
    task automatic send_sample(input logic [RAW_W-1:0] rx, input logic [RAW_W-1:0] ry,
                               input logic [PRESS_W-1:0] pr, input logic cons,
                               input bit fixed, input touch_report_t want);
        int            gap;
        touch_report_t predicted;
        if (cfg_valid)
            cfg_valid <= 1'b0;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, pr, ry, rx};
        s_tuser  <= cons;
        do
            @(posedge clk);
        while (!s_tready);
        // state only moves on acceptance; config is stable while words are in flight
        predicted = predict_report(rx, ry, pr, cons);
        pending_reports.push_back(fixed ? want : predicted);
        samples_sent++;
    endtask

    // ------------------------------------------------------------------
    // Sink: own pacing pattern, independent of the sender
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (sink_left == 0)
        begin
            sink_pace = sink_pace_t'($urandom_range(0, 2));
            sink_left = $urandom_range(4, 64);
        end
        sink_left--;
        case (sink_pace)
            SINK_OPEN:    m_tready <= 1'b1;
            SINK_CHOPPY:  m_tready <= ($urandom_range(0, 1) != 0);
            default:      m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Checker: every accepted output word against the oldest expectation
    // ------------------------------------------------------------------

    task automatic compare_field(input string what, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        touch_report_t seen;
        touch_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.touched  = m_tuser;
            seen.pressure = m_tdata[7:0];
            seen.x        = m_tdata[16:8];
            seen.y        = m_tdata[25:17];
            if (pending_reports.size() == 0)
            begin
                $display("%0t: unexpected report, expected none, got touched=%0d p=%0d x=%0d y=%0d",
                         $time, seen.touched, seen.pressure, seen.x, seen.y);
                mismatch_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                compare_field("touched", want.touched, seen.touched);
                compare_field("report_pressure", want.pressure, seen.pressure);
                compare_field("screen_x", want.x, seen.x);
                compare_field("screen_y", want.y, seen.y);
            end
            reports_checked++;
            if (seen.touched)
                touched_reports++;
        end
    end

    // Watchdog: a hang (lost word, stuck ready) ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("touch_affine_calibrate_rotate_unit_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin
        logic [WORD_W-1:0]  word_set [7];
        logic [WORD_W-1:0]  div;
        logic [RAW_W-1:0]   last_rx;
        logic [RAW_W-1:0]   last_ry;
        logic [RAW_W-1:0]   rx;
        logic [RAW_W-1:0]   ry;
        cal_style_t         style;
        int                 directed_count;

        // predictor starts from the reset state
        foreach (cal_coef[k])
            cal_coef[k] = '0;
        cal_divisor = '0;
        cal_orient  = ROT_0;
        held_x      = '0;
        held_y      = '0;
        used_x      = '0;
        used_y      = '0;
        nat_x       = '0;
        nat_y       = '0;
        last_rx     = '0;
        last_ry     = '0;

        // --- directed table ---------------------------------------------
        // Reset config: raw equal to the reset used value means no recompute.
        plan_sample(0, 0, 0, 1, 1, 1, 0, 0, 0);
        // Zero divisor with extreme raws: quotient all ones, clamps to zero.
        plan_sample(1023, 1023, 254, 1, 1, 1, 254, 0, 0);
        // No touch: held values kept, report all zero.
        plan_sample(5, 7, 1, 0, 1, 0, 0, 0, 0);

        // Identity-like calibration, then writes past the map that must not land.
        plan_reg(REG_COEF_A, 32'd1);
        plan_reg(REG_COEF_B, 32'd0);
        plan_reg(REG_COEF_C, 32'd0);
        plan_reg(REG_COEF_D, 32'd0);
        plan_reg(REG_COEF_E, 32'd1);
        plan_reg(REG_COEF_F, 32'd0);
        plan_reg(REG_DIVISOR, 32'd1);
        plan_reg(REG_ORIENT, 32'hFFFF_FFFC);   // upper bits ignored -> 0 deg
        plan_reg(REG_PAST_END, 32'd0);
        plan_reg(REG_INDEX_MAX, 32'd3);
        plan_sample(100, 50, 17, 1, 1, 1, 17, 100, 50);
        // size..2*size-1 clamps to size-1, 2*size and up clamps to zero
        plan_sample(400, 300, 3, 1, 1, 1, 3, 319, 239);
        plan_sample(640, 480, 9, 1, 1, 1, 9, 0, 0);
        plan_sample(639, 479, 128, 1, 1, 1, 128, 319, 239);
        plan_sample(639, 479, 64, 1, 1, 1, 64, 319, 239);

        // every rotation
        plan_reg(REG_ORIENT, 32'hFFFF_FFFD);   // 90 deg
        plan_sample(100, 50, 2, 1, 1, 1, 2, 50, 220);
        plan_reg(REG_ORIENT, 32'd2);           // 180 deg: both sizes show up
        plan_sample(0, 0, 32, 1, 1, 1, 32, 320, 240);
        plan_reg(REG_ORIENT, 32'd3);           // 270 deg
        plan_sample(319, 239, 4, 1, 1, 1, 4, 1, 319);
        plan_sample(0, 200, 16, 1, 1, 1, 16, 40, 0);
        plan_sample(1, 1, 8, 0, 1, 0, 0, 0, 0);

        // all-ones coefficients and divisor: wrapping sums
        plan_reg(REG_COEF_A, '1);
        plan_reg(REG_COEF_B, '1);
        plan_reg(REG_COEF_C, '1);
        plan_reg(REG_COEF_D, '1);
        plan_reg(REG_COEF_E, '1);
        plan_reg(REG_COEF_F, '1);
        plan_reg(REG_DIVISOR, '1);
        plan_reg(REG_ORIENT, 32'd0);
        plan_sample(1023, 1023, 254, 1, 0, 0, 0, 0, 0);
        plan_sample(0, 0, 1, 1, 0, 0, 0, 0, 0);

        // negative coefficients in two's complement, as real calibrations have
        plan_reg(REG_COEF_A, 32'hFFFF_FFFF);
        plan_reg(REG_COEF_B, 32'd0);
        plan_reg(REG_COEF_C, 32'd700);
        plan_reg(REG_COEF_D, 32'hFFFF_FFFE);
        plan_reg(REG_COEF_E, 32'd0);
        plan_reg(REG_COEF_F, 32'd900);
        plan_reg(REG_DIVISOR, 32'd1);
        plan_sample(500, 300, 77, 1, 0, 0, 0, 0, 0);
        plan_sample(1023, 0, 200, 1, 0, 0, 0, 0, 0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == STEP_REG)
            begin
                if (!cfg_valid)
                    drain_reports();
                write_reg(directed_plan[i].index, directed_plan[i].value);
            end
            else
            begin
                send_sample(directed_plan[i].rx, directed_plan[i].ry, directed_plan[i].pr,
                            directed_plan[i].cons, directed_plan[i].fixed,
                            directed_plan[i].want);
            end
        end
        directed_count = samples_sent;

        // --- random phases ----------------------------------------------
        // Each phase loads a fresh calibration: mostly plausible ones whose quotients
        // land around the panel size, plus raw random words and extreme words.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase % 4)
                0, 1:    style = CAL_SANE;
                2:       style = CAL_RAW;
                default: style = CAL_EXTREME;
            endcase
            case (style)
                CAL_SANE:
                begin
                    div = $urandom_range(1, 4096);
                    for (int axis = 0; axis < 2; axis++)
                    begin
                        // own-axis gain, cross gain, offset; a negative cross gain is
                        // paid for by a larger offset so the sum stays positive
                        word_set[axis*4]       = $urandom_range(0, div / 2);
                        word_set[axis*2 + 1]   = $urandom_range(0, div / 4);
                        word_set[axis*3 + 2]   = $urandom_range(0, div * 64);
                        if ($urandom_range(0, 1) != 0)
                        begin
                            word_set[axis*2 + 1] = -word_set[axis*2 + 1];
                            word_set[axis*3 + 2] = word_set[axis*3 + 2] + div * 300;
                        end
                    end
                    word_set[REG_DIVISOR] = div;
                end
                CAL_RAW:
                begin
                    foreach (word_set[k])
                        word_set[k] = $urandom;
                    if ($urandom_range(0, 2) == 0)
                        word_set[REG_DIVISOR] = '0;
                end
                default:
                begin
                    foreach (word_set[k])
                    begin
                        case ($urandom_range(0, 3))
                            0:       word_set[k] = '0;
                            1:       word_set[k] = 32'd1;
                            2:       word_set[k] = 32'h8000_0000;
                            default: word_set[k] = '1;
                        endcase
                    end
                end
            endcase

            drain_reports();
            for (int k = 0; k < 7; k++)
                write_reg(REG_COEF_A + IDX_W'(k), word_set[k]);
            write_reg(REG_ORIENT, $urandom);
            if ($urandom_range(0, 2) == 0)
                write_reg(($urandom_range(0, 1) != 0) ? REG_PAST_END : REG_INDEX_MAX, $urandom);

            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                rx      = next_raw(last_rx);
                ry      = next_raw(last_ry);
                last_rx = rx;
                last_ry = ry;
                send_sample(rx, ry, PRESS_W'($urandom_range(0, 254)),
                            ($urandom_range(0, 4) != 0), 1'b0, '0);
            end
        end

        // --- wrap-up ----------------------------------------------------
        drain_reports();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("sent %0d sample words (%0d directed) and %0d register writes; %0d reports, %0d touched",
                 samples_sent, directed_count, regs_written, reports_checked, touched_reports);
        $display("%0d random calibration phases (plausible, raw random, extreme words), all rotations",
                 NUM_PHASES);
        if (mismatch_count == 0)
            $display("touch_affine_calibrate_rotate_unit_tb: done, clean");
        else
            $display("touch_affine_calibrate_rotate_unit_tb: done, errors");
        $finish;
    end

endmodule
